// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; the decoder top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lzfd_pkg.sv =====
// Types, constants and sequencer microcode for the flagged-token decoder.
`timescale 1ns / 1ps

package lzfd_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = 12;
  localparam int OFFSET_W   = 12;
  localparam int LEN_W      = 4;
  localparam int COUNT_W    = 24;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 24'hFFFFFF;
  localparam logic [2:0]         CODE_LAST   = 3'd7;

  typedef enum logic [1:0] {PH_FLAG, PH_LIT, PH_OFS_HI, PH_OFS_LO} phase_t;

  typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_RD, ST_COPY, ST_LIT, ST_ERR} step_t;

  typedef enum logic [1:0] {EM_NONE, EM_COPY, EM_LIT, EM_ERR} emit_t;

  typedef enum logic [1:0] {BR_NEXT, BR_DISPATCH, BR_CHECK, BR_MORE} branch_t;

  typedef struct packed {
    emit_t   emit;
    logic    mem_rd;
    logic    finish;
    branch_t br;
    step_t   nxt;
  } ctrl_t;

  typedef struct packed {
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
  } hist_req_t;

  // Control store: one word per step.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      ST_IDLE:  w = '{emit: EM_NONE, mem_rd: 1'b0, finish: 1'b0, br: BR_DISPATCH, nxt: ST_IDLE};
      ST_CHECK: w = '{emit: EM_NONE, mem_rd: 1'b0, finish: 1'b0, br: BR_CHECK,    nxt: ST_IDLE};
      ST_RD:    w = '{emit: EM_NONE, mem_rd: 1'b1, finish: 1'b0, br: BR_NEXT,     nxt: ST_COPY};
      ST_COPY:  w = '{emit: EM_COPY, mem_rd: 1'b0, finish: 1'b0, br: BR_MORE,     nxt: ST_IDLE};
      ST_LIT:   w = '{emit: EM_LIT,  mem_rd: 1'b0, finish: 1'b1, br: BR_NEXT,     nxt: ST_IDLE};
      ST_ERR:   w = '{emit: EM_ERR,  mem_rd: 1'b0, finish: 1'b1, br: BR_NEXT,     nxt: ST_IDLE};
      default:  w = '{emit: EM_NONE, mem_rd: 1'b0, finish: 1'b0, br: BR_DISPATCH, nxt: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/lzfd_history.sv =====
// History ring: one write and one registered read per cycle, fill count for unwritten entries.
`timescale 1ns / 1ps

module lzfd_history (
  input  logic                clk,
  input  logic                rst_n,
  input  lzfd_pkg::hist_req_t req,
  output logic [7:0]          rd_data
);
  import lzfd_pkg::*;

  logic [7:0]       mem_r [HIST_DEPTH];
  logic [7:0]       data_r;
  logic             written_r;
  logic [HIST_AW:0] fill_r;
  logic [HIST_AW:0] fill_nxt;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_r <= mem_r[req.rd_addr];
    end
  end

  // Entries are written in address order from zero, so the count tells which hold data.
  always_comb begin
    fill_nxt = fill_r;
    if (req.wr_en && !fill_r[HIST_AW]) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      written_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (req.rd_en) begin
        written_r <= fill_r[HIST_AW] || (req.rd_addr < fill_r[HIST_AW-1:0]);
      end
    end
  end

  assign rd_data = written_r ? data_r : 8'h00;

endmodule

// ===== rtl/lz77_flagged_token_decoder.sv =====
// Top level of the flagged-token decompressor: parser, microcoded sequencer, output register.
`timescale 1ns / 1ps

// Decodes a flag-byte LZSS stream (12-bit offset, 4-bit length) one input item at a
// time. A code is accepted, then checked against output_limit in the check step; each
// copied byte takes a history read step, then a write-and-emit step, and the literal
// follows in its own step. Emit steps wait while the output register is full and stalled.
// The copy loop runs through the single-read history RAM. Input is taken only while
// the sequencer is idle; a result waiting in the output register does not block the
// next input item. History reads as zero until written; a fill counter tracks this,
// so there is no clearing pass after reset. An overflowed block yields one error item
// and then drops input up to end_of_block.
module lz77_flagged_token_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_overflow_error
);
  import lzfd_pkg::*;

  `include "assert_macros.svh"

  step_t                step_r, step_nxt;
  phase_t               phase_r, phase_nxt;
  logic [7:0]           flag_r, flag_nxt;
  logic [2:0]           code_idx_r, code_idx_nxt;
  logic [7:0]           lit_r, lit_nxt;
  logic [7:0]           ofs_hi_r, ofs_hi_nxt;
  logic [OFFSET_W-1:0]  offset_r, offset_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [COUNT_W-1:0]   bytes_r, bytes_nxt;
  logic                 err_stop_r, err_stop_nxt;
  logic                 eob_r, eob_nxt;
  logic [HIST_AW-1:0]   wi_r, wi_nxt;
  logic [COUNT_W-1:0]   limit_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_err_r, out_err_nxt;

  ctrl_t                cw;
  hist_req_t            hreq;
  logic [7:0]           hist_data;
  logic                 in_acc;
  logic                 out_free;
  logic                 restart;
  logic [COUNT_W:0]     need;
  logic                 over;

  assign cw       = ucode(step_r);
  assign in_stall = (step_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign need = {1'b0, bytes_r} + (COUNT_W+1)'(len_r) + (COUNT_W+1)'(1);
  assign over = need > {1'b0, limit_r};

  always_comb begin
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    flag_nxt      = flag_r;
    code_idx_nxt  = code_idx_r;
    lit_nxt       = lit_r;
    ofs_hi_nxt    = ofs_hi_r;
    offset_nxt    = offset_r;
    len_nxt       = len_r;
    bytes_nxt     = bytes_r;
    err_stop_nxt  = err_stop_r;
    eob_nxt       = eob_r;
    wi_nxt        = wi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    restart       = 1'b0;

    hreq.rd_en   = cw.mem_rd;
    hreq.rd_addr = HIST_AW'(wi_r - HIST_AW'(offset_r) - HIST_AW'(1));
    hreq.wr_en   = 1'b0;
    hreq.wr_addr = wi_r;
    hreq.wr_data = lit_r;

    case (cw.br)
      BR_DISPATCH: begin
        if (in_acc) begin
          eob_nxt = in_end_of_block;
          restart = in_end_of_block;
          if (!err_stop_r) begin
            case (phase_r)
              PH_FLAG: begin
                flag_nxt  = in_byte;
                phase_nxt = PH_LIT;
              end
              PH_LIT: begin
                lit_nxt = in_byte;
                if (flag_r[code_idx_r]) begin
                  phase_nxt = PH_OFS_HI;
                end else begin
                  offset_nxt = '0;
                  len_nxt    = '0;
                  step_nxt   = ST_CHECK;
                  restart    = 1'b0;
                end
              end
              PH_OFS_HI: begin
                ofs_hi_nxt = in_byte;
                phase_nxt  = PH_OFS_LO;
              end
              PH_OFS_LO: begin
                offset_nxt = {ofs_hi_r, in_byte[7:4]};
                len_nxt    = in_byte[LEN_W-1:0];
                step_nxt   = ST_CHECK;
                restart    = 1'b0;
              end
              default: begin
                phase_nxt = PH_FLAG;
              end
            endcase
          end
        end
      end
      BR_CHECK: begin
        if (over) begin
          step_nxt = ST_ERR;
        end else begin
          bytes_nxt = need[COUNT_W-1:0];
          step_nxt  = (len_r == '0) ? ST_LIT : ST_RD;
        end
      end
      BR_MORE: begin
        if (out_free) begin
          step_nxt = (len_r == LEN_W'(1)) ? ST_LIT : ST_RD;
        end
      end
      default: begin
        if (cw.emit == EM_NONE || out_free) begin
          step_nxt = cw.nxt;
        end
      end
    endcase

    if (out_free) begin
      case (cw.emit)
        EM_COPY: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hist_data;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          hreq.wr_en    = 1'b1;
          hreq.wr_data  = hist_data;
          wi_nxt        = wi_r + 1'b1;
          len_nxt       = len_r - 1'b1;
        end
        EM_LIT: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = lit_r;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b0;
          hreq.wr_en    = 1'b1;
          wi_nxt        = wi_r + 1'b1;
          if (code_idx_r == CODE_LAST) begin
            code_idx_nxt = '0;
            phase_nxt    = PH_FLAG;
          end else begin
            code_idx_nxt = code_idx_r + 1'b1;
            phase_nxt    = PH_LIT;
          end
        end
        EM_ERR: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          err_stop_nxt  = 1'b1;
        end
        default: begin
        end
      endcase
      if (cw.finish) begin
        restart = eob_r;
      end
    end

    if (restart) begin
      phase_nxt    = PH_FLAG;
      flag_nxt     = '0;
      code_idx_nxt = '0;
      bytes_nxt    = '0;
      err_stop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      phase_r     <= PH_FLAG;
      flag_r      <= '0;
      code_idx_r  <= '0;
      lit_r       <= '0;
      ofs_hi_r    <= '0;
      bytes_r     <= '0;
      err_stop_r  <= 1'b0;
      wi_r        <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      flag_r      <= flag_nxt;
      code_idx_r  <= code_idx_nxt;
      lit_r       <= lit_nxt;
      ofs_hi_r    <= ofs_hi_nxt;
      bytes_r     <= bytes_nxt;
      err_stop_r  <= err_stop_nxt;
      wi_r        <= wi_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    offset_r   <= offset_nxt;
    len_r      <= len_nxt;
    eob_r      <= eob_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  lzfd_history u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .rd_data (hist_data)
  );

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last_of_run    = out_last_r;
  assign out_overflow_error = out_err_r;

  `ASSERT_CLK(a_rd_then_copy, clk, rst_n, (step_r == ST_RD) |=> (step_r == ST_COPY), "read step not followed by copy")
  `ASSERT_CLK(a_copy_len, clk, rst_n, (step_r == ST_COPY && out_free) |=> (len_r == $past(len_r) - 1'b1), "copy length not decremented")
  `ASSERT_CLK(a_wi_step, clk, rst_n, hreq.wr_en |=> (wi_r == $past(wi_r) + 1'b1), "write index did not advance")
  `ASSERT_ALWAYS(a_err_last, clk, (out_valid_r && out_err_r) |-> out_last_r, "error item without last flag")

endmodule

// ===== verif/lz77_flagged_token_decoder_tb.sv =====
// Self-checking testbench for the flagged-token LZSS decoder.
`timescale 1ns / 1ps

module lz77_flagged_token_decoder_tb;
  import lzfd_pkg::*;

  typedef struct {
    bit [7:0] data;
    bit       last;
    bit       err;
  } decoded_t;

  // Tracks the decoder state and the decoded bytes still owed by the block.
  class decoded_byte_board;
    bit [7:0]         ring [HIST_DEPTH];
    bit [HIST_AW-1:0] wr_ptr;
    phase_t           phase;
    bit [7:0]         flag_byte;
    bit [2:0]         code_no;
    bit [7:0]         literal;
    bit [7:0]         offset_hi;
    int unsigned      produced;
    bit               halted;
    int unsigned      limit;
    decoded_t         decoded_q[$];
    int               mismatch_count;

    function new();
      foreach (ring[i]) ring[i] = 8'h00;
      wr_ptr = '0;
      phase = PH_FLAG;
      flag_byte = 8'h00;
      code_no = 3'd0;
      literal = 8'h00;
      offset_hi = 8'h00;
      produced = 0;
      halted = 1'b0;
      limit = 32'(LIMIT_RESET);
      mismatch_count = 0;
    endfunction

    function void set_limit(bit [COUNT_W-1:0] v);
      limit = 32'(v);
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void emit(bit [7:0] d, bit last, bit err);
      decoded_t r;
      r.data = d;
      r.last = last;
      r.err = err;
      decoded_q.push_back(r);
    endfunction

    // Copy len bytes from back+1 behind the write pointer, then the held literal; an error item on overflow.
    function void expand_code(bit [OFFSET_W-1:0] back, bit [LEN_W-1:0] len);
      bit [7:0]         d;
      bit [HIST_AW-1:0] src;
      if (produced + len + 1 > limit) begin
        halted = 1'b1;
        emit(8'h00, 1'b1, 1'b1);
        return;
      end
      for (int k = 0; k < len; k++) begin
        src = HIST_AW'(wr_ptr - back - 1);
        d = ring[src];
        ring[wr_ptr] = d;
        wr_ptr++;
        emit(d, 1'b0, 1'b0);
      end
      ring[wr_ptr] = literal;
      wr_ptr++;
      emit(literal, 1'b1, 1'b0);
      produced = (produced + len + 1) & 32'h00FF_FFFF;
      if (code_no == CODE_LAST) begin
        code_no = 3'd0;
        phase = PH_FLAG;
      end else begin
        code_no++;
        phase = PH_LIT;
      end
    endfunction

    function void absorb_byte(bit [7:0] b, bit eob);
      if (!halted) begin
        case (phase)
          PH_FLAG: begin
            flag_byte = b;
            phase = PH_LIT;
          end
          PH_LIT: begin
            literal = b;
            if (flag_byte[code_no]) phase = PH_OFS_HI;
            else expand_code('0, '0);
          end
          PH_OFS_HI: begin
            offset_hi = b;
            phase = PH_OFS_LO;
          end
          default: begin
            expand_code({offset_hi, b[7:4]}, b[3:0]);
          end
        endcase
      end
      if (eob) begin
        phase = PH_FLAG;
        flag_byte = 8'h00;
        code_no = 3'd0;
        produced = 0;
        halted = 1'b0;
      end
    endfunction

    function void check_decoded(bit [7:0] d, bit last, bit err);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual byte %02h last %0d error %0d",
                 $time, d, last, err);
        mismatch_count++;
        return;
      end
      want = decoded_q.pop_front();
      if (want.data != d) begin
        $display("%0t: out_byte mismatch: expected %02h actual %02h", $time, want.data, d);
        mismatch_count++;
      end
      if (want.last != last) begin
        $display("%0t: out_last_of_run mismatch: expected %0d actual %0d",
                 $time, want.last, last);
        mismatch_count++;
      end
      if (want.err != err) begin
        $display("%0t: out_overflow_error mismatch: expected %0d actual %0d",
                 $time, want.err, err);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_end_of_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        out_overflow_error;

  decoded_byte_board board;
  bit [7:0]          stream_q[$];
  bit                steady = 1'b0;
  int                hold_len = 0;
  int                sent_total = 0;

  lz77_flagged_token_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_end_of_block    (in_end_of_block),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last_of_run    (out_last_of_run),
    .out_overflow_error (out_overflow_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stall per item, plus an optional long hold-off.
  initial begin : receiver
    int gap;
    int hold_left;
    gap = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        board.check_decoded(out_byte, out_last_of_run, out_overflow_error);
        gap = steady ? 0 : $urandom_range(0, 6);
      end
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (gap > 0) begin
        out_stall <= 1'b1;
        gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(bit [7:0] b, bit eob);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_block <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.absorb_byte(b, eob);
    sent_total++;
  endtask

  // Sends the queued bytes as one block, end_of_block on the last one.
  task automatic send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Pause input until every owed item is out and the sequencer has gone idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(bit [23:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    board.set_limit(v);
    cfg_wr_en <= 1'b0;
  endtask

  // Well-formed block; with cut set, the last code is a match missing its tail.
  task automatic build_block(int codes, int match_pct, bit cut);
    bit [7:0]  flags;
    bit [11:0] back;
    int        flag_pos;
    stream_q.delete();
    flags = 8'h00;
    flag_pos = 0;
    if (codes == 0) stream_q.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < codes; k++) begin
      if (k % 8 == 0) begin
        for (int j = 0; j < 8; j++) flags[j] = ($urandom_range(0, 99) < match_pct);
        flag_pos = stream_q.size();
        stream_q.push_back(flags);
      end
      if (cut && k == codes - 1) begin
        flags[k % 8] = 1'b1;
        stream_q[flag_pos] = flags;
      end
      stream_q.push_back(8'($urandom_range(0, 255)));
      if (flags[k % 8]) begin
        back = $urandom_range(0, 1) ? 12'($urandom_range(0, 15)) : 12'($urandom);
        stream_q.push_back(back[11:4]);
        stream_q.push_back({back[3:0], 4'($urandom_range(0, 15))});
      end
    end
    if (cut && codes > 0) repeat ($urandom_range(1, 2)) void'(stream_q.pop_back());
  endtask

  initial begin
    int rand_start;
    int phase_no;
    int pick;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limit(24'hFFFFFF);

    // Longest copy reaching back into reset history, overlapping copy, plain
    // literal, then a match code cut off by end of block.
    stream_q = '{8'h0B, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'hA5, 8'h5A, 8'h12};
    send_stream();
    stream_q = '{8'h80};
    send_stream();

    // Zero limit: first code overflows, rest of the block is dropped.
    settle();
    write_limit(24'h000000);
    stream_q = '{8'h00, 8'h33, 8'h44, 8'h55};
    send_stream();

    // Match fills the limit exactly, next literal overflows on the end byte.
    settle();
    write_limit(24'd3);
    stream_q = '{8'h01, 8'h11, 8'h00, 8'h02, 8'h22};
    send_stream();

    // Limit lowered in the middle of a block.
    settle();
    write_limit(24'hFFFFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    settle();
    write_limit(24'd2);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);

    rand_start = sent_total;
    phase_no = 0;
    while (sent_total < rand_start + 300) begin
      settle();
      case ($urandom_range(0, 9))
        0: write_limit(24'h000000);
        1: write_limit(24'($urandom_range(1, 24)));
        2: write_limit(24'($urandom_range(25, 300)));
        3: write_limit(24'hFFFFFF);
        default: write_limit(24'($urandom_range(1000, 24'hFFFFFF)));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        // Receiver holds off while input keeps coming, so the block backs up.
        steady = 1'b1;
        hold_len = 250;
        build_block(20, 70, 1'b0);
        send_stream();
      end
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          stream_q.delete();
          repeat ($urandom_range(3, 10)) stream_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          build_block($urandom_range(0, 20), 50, pick == 1);
        end
        send_stream();
      end
      phase_no++;
    end

    steady = 1'b0;
    settle();
    if (board.mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== lz77_flagged_token_decoder.f =====
+incdir+rtl
rtl/lzfd_pkg.sv
rtl/lzfd_history.sv
rtl/lz77_flagged_token_decoder.sv
verif/lz77_flagged_token_decoder_tb.sv
